/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the date-time adder RTL; each checks on the
// rising edge of clk and is held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTAN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTAN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dtan_pkg.sv */
// ----------------------------------------------------------------------------
// dtan_pkg
// Widths, calendar constants, shared-unit structs and the month length
// table for the date-time adder.
// ----------------------------------------------------------------------------
`default_nettype none

package dtan_pkg;

    // datapath widths of the shared unit
    localparam int LO_W  = 8;
    localparam int HI_W  = 16;
    localparam int LIM_W = 7;

    // calendar limits
    localparam logic [LIM_W-1:0] SEC_THR   = 7'd59;
    localparam logic [LIM_W-1:0] SEC_SUB   = 7'd60;
    localparam logic [LIM_W-1:0] MIN_THR   = 7'd59;
    localparam logic [LIM_W-1:0] MIN_SUB   = 7'd60;
    localparam logic [LIM_W-1:0] HOUR_THR  = 7'd23;
    localparam logic [LIM_W-1:0] HOUR_SUB  = 7'd24;
    localparam logic [LIM_W-1:0] MONTH_THR = 7'd12;
    localparam logic [LIM_W-1:0] MONTH_SUB = 7'd12;

    localparam logic [HI_W-1:0] YEAR_MAX = 16'd9999;

    // divisibility by 25: multiply by the inverse of 25 mod 2^16, then
    // the product is small exactly for multiples of 25
    localparam logic [HI_W-1:0] INV25     = 16'd23593;
    localparam logic [HI_W-1:0] DIV25_LIM = 16'd2621;

    // saturated result
    localparam logic [3:0] SAT_MONTH  = 4'd12;
    localparam logic [4:0] SAT_DAY    = 5'd31;
    localparam logic [4:0] SAT_HOUR   = 5'd23;
    localparam logic [5:0] SAT_MINUTE = 6'd59;
    localparam logic [5:0] SAT_SECOND = 6'd59;

    // operands of the shared compare-subtract-increment unit
    typedef struct packed {
        logic [LO_W-1:0]  lo;
        logic [LIM_W-1:0] thr;
        logic [LIM_W-1:0] sub;
        logic [HI_W-1:0]  hi;
    } unit_op_t;

    // result of the shared unit
    typedef struct packed {
        logic             gt;
        logic [LO_W-1:0]  lo;
        logic [HI_W-1:0]  hi;
    } unit_res_t;

    // days in a common-year month; unknown months fall back to january
    function automatic logic [4:0] month_days(input logic [4:0] month);
        logic [4:0] d;
        case (month)
            5'd2:    d = 5'd28;
            5'd4:    d = 5'd30;
            5'd6:    d = 5'd30;
            5'd9:    d = 5'd30;
            5'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/dtan_if.sv */
// ----------------------------------------------------------------------------
// dtan_if
// Valid/ready channels of the date-time adder: request beats carry the
// starting date-time and the offset, response beats the normalized sum.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtan_req_if;
    logic        valid;
    logic        ready;
    logic [13:0] base_year;
    logic [3:0]  base_month;
    logic [4:0]  base_day;
    logic [4:0]  base_hour;
    logic [5:0]  base_minute;
    logic [5:0]  base_second;
    logic [13:0] add_years;
    logic [3:0]  add_months;
    logic [4:0]  add_days;
    logic [4:0]  add_hours;
    logic [5:0]  add_minutes;
    logic [5:0]  add_seconds;

    modport source (
        output valid, base_year, base_month, base_day, base_hour, base_minute,
               base_second, add_years, add_months, add_days, add_hours,
               add_minutes, add_seconds,
        input  ready
    );

    modport sink (
        input  valid, base_year, base_month, base_day, base_hour, base_minute,
               base_second, add_years, add_months, add_days, add_hours,
               add_minutes, add_seconds,
        output ready
    );
endinterface

interface dtan_rsp_if;
    logic        valid;
    logic        ready;
    logic [13:0] sum_year;
    logic [3:0]  sum_month;
    logic [4:0]  sum_day;
    logic [4:0]  sum_hour;
    logic [5:0]  sum_minute;
    logic [5:0]  sum_second;
    logic        year_overflow;

    modport source (
        output valid, sum_year, sum_month, sum_day, sum_hour, sum_minute,
               sum_second, year_overflow,
        input  ready
    );

    modport sink (
        input  valid, sum_year, sum_month, sum_day, sum_hour, sum_minute,
               sum_second, year_overflow,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/dtan_unit.sv */
// ----------------------------------------------------------------------------
// dtan_unit
// Shared carry unit: if the low field is past its threshold, subtract the
// field modulus and increment the next field up; otherwise pass both.
// ----------------------------------------------------------------------------
`default_nettype none

module dtan_unit (
    input  dtan_pkg::unit_op_t  op,
    output dtan_pkg::unit_res_t res
);

    logic                      gt;
    logic [dtan_pkg::LO_W-1:0] lo_dec;
    logic [dtan_pkg::HI_W-1:0] hi_inc;

    // compare, subtract and increment share one select
    assign gt     = op.lo > dtan_pkg::LO_W'(op.thr);
    assign lo_dec = op.lo - dtan_pkg::LO_W'(op.sub);
    assign hi_inc = op.hi + dtan_pkg::HI_W'(1);

    assign res.gt = gt;
    assign res.lo = gt ? lo_dec : op.lo;
    assign res.hi = gt ? hi_inc : op.hi;

endmodule

`default_nettype wire

/* hdl/dtan_mlen.sv */
// ----------------------------------------------------------------------------
// dtan_mlen
// Month length lookup with the gregorian leap rule (4 / 100 / 400).
// ----------------------------------------------------------------------------
`default_nettype none

module dtan_mlen (
    input  logic [dtan_pkg::HI_W-1:0] year,
    input  logic [4:0]                month,
    output logic [4:0]                len
);

    logic [dtan_pkg::HI_W-1:0] prod;
    logic                      div4;
    logic                      div16;
    logic                      div25;
    logic                      leap;

    // multiple of 25 test by modular inverse
    assign prod  = year * dtan_pkg::INV25;
    assign div25 = prod <= dtan_pkg::DIV25_LIM;

    // div by 100 is div4 and div25, div by 400 is div16 and div25
    assign div4  = year[1:0] == 2'd0;
    assign div16 = year[3:0] == 4'd0;
    assign leap  = (div4 && !div25) || (div16 && div25);

    // february gets one more day in leap years
    assign len = dtan_pkg::month_days(month) + 5'((month == 5'd2) && leap);

endmodule

`default_nettype wire

/* hdl/datetime_add_normalize.sv */
// ----------------------------------------------------------------------------
// datetime_add_normalize
// Adds a date-time offset to a gregorian date-time and normalizes the sum
// by carry passes through one shared compare-subtract-increment unit.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------
//  req     | in  | base date-time and offset, twelve fields
//  rsp     | out | normalized sum and year_overflow flag
//
//  an accepted request steps through the sec, min, hour and month carry
//  states, the month length lookup and the day step before the response
//  is loaded; each carry step is one pass through the shared unit, and
//  every day roll costs a month wrap, a month length lookup and a day step
//  req.ready is high only while the sequencer is idle
//  the response register lets a new request in while the previous beat waits
//  rst_n clears the sequencer and the response valid asynchronously
//
`default_nettype none

`include "assert_macros.svh"

module datetime_add_normalize (
    input  logic           clk,
    input  logic           rst_n,
    dtan_req_if.sink       req,
    dtan_rsp_if.source     rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_MON,
        ST_LEN,
        ST_DAY,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // working fields, wide enough for unreduced sums
    logic [6:0]                sec_reg,   sec_next;
    logic [7:0]                min_reg,   min_next;
    logic [6:0]                hour_reg,  hour_next;
    logic [6:0]                day_reg,   day_next;
    logic [4:0]                month_reg, month_next;
    logic [dtan_pkg::HI_W-1:0] year_reg,  year_next;
    logic [4:0]                len_reg,   len_next;

    // response register
    logic        rsp_valid_reg,  rsp_valid_next;
    logic [13:0] sum_year_reg,   sum_year_next;
    logic [3:0]  sum_month_reg,  sum_month_next;
    logic [4:0]  sum_day_reg,    sum_day_next;
    logic [4:0]  sum_hour_reg,   sum_hour_next;
    logic [5:0]  sum_minute_reg, sum_minute_next;
    logic [5:0]  sum_second_reg, sum_second_next;
    logic        ovf_reg,        ovf_next;

    dtan_pkg::unit_op_t  op;
    dtan_pkg::unit_res_t res;
    logic [4:0]          mlen;
    logic                req_beat;
    logic                load_rsp;
    logic                ovf;
    logic [3:0]          base_month_fix;
    logic [4:0]          base_day_fix;

    dtan_unit u_unit (
        .op  (op),
        .res (res)
    );

    dtan_mlen u_mlen (
        .year  (year_reg),
        .month (month_reg),
        .len   (mlen)
    );

    assign req.ready = state_reg == ST_IDLE;
    assign req_beat  = req.valid && req.ready;
    assign load_rsp  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign ovf       = year_reg > dtan_pkg::YEAR_MAX;

    // zero month and zero day are taken as one
    assign base_month_fix = (req.base_month == 4'd0) ? 4'd1 : req.base_month;
    assign base_day_fix   = (req.base_day == 5'd0) ? 5'd1 : req.base_day;

    // operand select for the shared unit
    always_comb
    begin
        op = '0;
        unique case (state_reg)
            ST_SEC:
            begin
                op.lo  = 8'(sec_reg);
                op.thr = dtan_pkg::SEC_THR;
                op.sub = dtan_pkg::SEC_SUB;
                op.hi  = 16'(min_reg);
            end
            ST_MIN:
            begin
                op.lo  = min_reg;
                op.thr = dtan_pkg::MIN_THR;
                op.sub = dtan_pkg::MIN_SUB;
                op.hi  = 16'(hour_reg);
            end
            ST_HOUR:
            begin
                op.lo  = 8'(hour_reg);
                op.thr = dtan_pkg::HOUR_THR;
                op.sub = dtan_pkg::HOUR_SUB;
                op.hi  = 16'(day_reg);
            end
            ST_MON:
            begin
                op.lo  = 8'(month_reg);
                op.thr = dtan_pkg::MONTH_THR;
                op.sub = dtan_pkg::MONTH_SUB;
                op.hi  = year_reg;
            end
            ST_DAY:
            begin
                op.lo  = 8'(day_reg);
                op.thr = 7'(len_reg);
                op.sub = 7'(len_reg);
                op.hi  = 16'(month_reg);
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

    // sequencer and field updates
    always_comb
    begin
        state_next      = state_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        len_next        = len_reg;
        rsp_valid_next  = rsp_valid_reg;
        sum_year_next   = sum_year_reg;
        sum_month_next  = sum_month_reg;
        sum_day_next    = sum_day_reg;
        sum_hour_next   = sum_hour_reg;
        sum_minute_next = sum_minute_reg;
        sum_second_next = sum_second_reg;
        ovf_next        = ovf_reg;

        // response beat taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    sec_next   = 7'(req.base_second) + 7'(req.add_seconds);
                    min_next   = 8'(req.base_minute) + 8'(req.add_minutes);
                    hour_next  = 7'(req.base_hour) + 7'(req.add_hours);
                    day_next   = 7'(base_day_fix) + 7'(req.add_days);
                    month_next = 5'(base_month_fix) + 5'(req.add_months);
                    year_next  = 16'(req.base_year) + 16'(req.add_years);
                    state_next = ST_SEC;
                end
            end
            ST_SEC:
            begin
                sec_next = res.lo[6:0];
                min_next = res.hi[7:0];
                if (!res.gt)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                min_next  = res.lo;
                hour_next = res.hi[6:0];
                if (!res.gt)
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                hour_next = res.lo[6:0];
                day_next  = res.hi[6:0];
                if (!res.gt)
                begin
                    state_next = ST_MON;
                end
            end
            ST_MON:
            begin
                month_next = res.lo[4:0];
                year_next  = res.hi;
                if (!res.gt)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                len_next   = mlen;
                state_next = ST_DAY;
            end
            ST_DAY:
            begin
                // a day roll bumps the month, which may wrap into the year
                day_next   = res.lo[6:0];
                month_next = res.hi[4:0];
                state_next = res.gt ? ST_MON : ST_DONE;
            end
            ST_DONE:
            begin
                if (load_rsp)
                begin
                    rsp_valid_next  = 1'b1;
                    ovf_next        = ovf;
                    sum_year_next   = ovf ? dtan_pkg::YEAR_MAX[13:0] : year_reg[13:0];
                    sum_month_next  = ovf ? dtan_pkg::SAT_MONTH : month_reg[3:0];
                    sum_day_next    = ovf ? dtan_pkg::SAT_DAY : day_reg[4:0];
                    sum_hour_next   = ovf ? dtan_pkg::SAT_HOUR : hour_reg[4:0];
                    sum_minute_next = ovf ? dtan_pkg::SAT_MINUTE : min_reg[5:0];
                    sum_second_next = ovf ? dtan_pkg::SAT_SECOND : sec_reg[5:0];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            sec_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
            day_reg        <= '0;
            month_reg      <= '0;
            year_reg       <= '0;
            len_reg        <= '0;
            sum_year_reg   <= '0;
            sum_month_reg  <= '0;
            sum_day_reg    <= '0;
            sum_hour_reg   <= '0;
            sum_minute_reg <= '0;
            sum_second_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            day_reg        <= day_next;
            month_reg      <= month_next;
            year_reg       <= year_next;
            len_reg        <= len_next;
            sum_year_reg   <= sum_year_next;
            sum_month_reg  <= sum_month_next;
            sum_day_reg    <= sum_day_next;
            sum_hour_reg   <= sum_hour_next;
            sum_minute_reg <= sum_minute_next;
            sum_second_reg <= sum_second_next;
            ovf_reg        <= ovf_next;
        end
    end

    // response port
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.sum_year      = sum_year_reg;
    assign rsp.sum_month     = sum_month_reg;
    assign rsp.sum_day       = sum_day_reg;
    assign rsp.sum_hour      = sum_hour_reg;
    assign rsp.sum_minute    = sum_minute_reg;
    assign rsp.sum_second    = sum_second_reg;
    assign rsp.year_overflow = ovf_reg;

    // checks
    `DTAN_ASSERT_NEXT(a_req_starts_seq, req_beat, state_reg == ST_SEC,
        "accepted request did not start the carry sequence")
    `DTAN_ASSERT_NOW(a_len_month_wrapped, state_reg == ST_LEN,
        month_reg >= 5'd1 && month_reg <= 5'd12,
        "month out of range at month length lookup")
    `DTAN_ASSERT_NOW(a_ovf_saturates, rsp.valid && rsp.year_overflow,
        rsp.sum_year == dtan_pkg::YEAR_MAX[13:0] && rsp.sum_month == dtan_pkg::SAT_MONTH,
        "overflowed response not saturated")
    `DTAN_ASSERT_NOW(a_rsp_normalized, rsp.valid && !rsp.year_overflow,
        rsp.sum_month >= 4'd1 && rsp.sum_month <= 4'd12 && rsp.sum_second <= 6'd59
            && rsp.sum_minute <= 6'd59 && rsp.sum_hour <= 5'd23,
        "response time or month not normalized")

endmodule

`default_nettype wire
